/* rtl/stt_pkg.sv */
// ----------------------------------------------------------------------------
// stt_pkg
// Types and constants shared by the source text tokenizer modules.
// ----------------------------------------------------------------------------
package stt_pkg;

	typedef struct packed {
		logic [7:0] char_byte;
		logic       end_of_input;
	} in_item_t;

	typedef struct packed {
		logic [5:0]  token_kind;
		logic [23:0] lexeme_start;
		logic [23:0] lexeme_length;
		logic [23:0] line_number;
		logic        last_of_run;
	} result_t;

	// all results caused by one byte, count is 1..3
	typedef struct packed {
		result_t [2:0] res;
		logic [1:0]    count;
	} group_t;

	typedef enum logic [3:0] {
		MODE_IDLE,
		MODE_EQ,
		MODE_LT,
		MODE_GT,
		MODE_DOT,
		MODE_SLASH,
		MODE_COMMENT,
		MODE_STRING,
		MODE_INT,
		MODE_NDOT,
		MODE_FRAC,
		MODE_WORD
	} scan_mode_t;

	localparam int QUEUE_DEPTH = 4;
	localparam int QPTR_BITS   = 2;

	localparam logic [5:0] KIND_EOF       = 6'd0;
	localparam logic [5:0] KIND_BACKSLASH = 6'd1;
	localparam logic [5:0] KIND_PLUS      = 6'd2;
	localparam logic [5:0] KIND_MINUS     = 6'd3;
	localparam logic [5:0] KIND_STAR      = 6'd4;
	localparam logic [5:0] KIND_CARET     = 6'd5;
	localparam logic [5:0] KIND_LPAREN    = 6'd6;
	localparam logic [5:0] KIND_RPAREN    = 6'd7;
	localparam logic [5:0] KIND_LBRACK    = 6'd8;
	localparam logic [5:0] KIND_RBRACK    = 6'd9;
	localparam logic [5:0] KIND_LBRACE    = 6'd10;
	localparam logic [5:0] KIND_RBRACE    = 6'd11;
	localparam logic [5:0] KIND_COLON     = 6'd12;
	localparam logic [5:0] KIND_COMMA     = 6'd13;
	localparam logic [5:0] KIND_EQEQ      = 6'd14;
	localparam logic [5:0] KIND_EQ        = 6'd15;
	localparam logic [5:0] KIND_LE        = 6'd16;
	localparam logic [5:0] KIND_LT        = 6'd17;
	localparam logic [5:0] KIND_GE        = 6'd18;
	localparam logic [5:0] KIND_GT        = 6'd19;
	localparam logic [5:0] KIND_DOTDOT    = 6'd20;
	localparam logic [5:0] KIND_DOT       = 6'd21;
	localparam logic [5:0] KIND_NE        = 6'd22;
	localparam logic [5:0] KIND_SLASH     = 6'd23;
	localparam logic [5:0] KIND_STRING    = 6'd24;
	localparam logic [5:0] KIND_NUMBER    = 6'd25;
	localparam logic [5:0] KIND_IDENT     = 6'd26;
	localparam logic [5:0] KIND_AND       = 6'd27;
	localparam logic [5:0] KIND_BAD       = 6'd33;
	localparam logic [5:0] KIND_UNTERM    = 6'd34;

	localparam logic [7:0] CH_BACKSLASH = 8'h5C;
	localparam logic [7:0] CH_PLUS      = 8'h2B;
	localparam logic [7:0] CH_MINUS     = 8'h2D;
	localparam logic [7:0] CH_STAR      = 8'h2A;
	localparam logic [7:0] CH_CARET     = 8'h5E;
	localparam logic [7:0] CH_LPAREN    = 8'h28;
	localparam logic [7:0] CH_RPAREN    = 8'h29;
	localparam logic [7:0] CH_LBRACK    = 8'h5B;
	localparam logic [7:0] CH_RBRACK    = 8'h5D;
	localparam logic [7:0] CH_LBRACE    = 8'h7B;
	localparam logic [7:0] CH_RBRACE    = 8'h7D;
	localparam logic [7:0] CH_COLON     = 8'h3A;
	localparam logic [7:0] CH_COMMA     = 8'h2C;
	localparam logic [7:0] CH_EQUAL     = 8'h3D;
	localparam logic [7:0] CH_LESS      = 8'h3C;
	localparam logic [7:0] CH_GREATER   = 8'h3E;
	localparam logic [7:0] CH_DOT       = 8'h2E;
	localparam logic [7:0] CH_SLASH     = 8'h2F;
	localparam logic [7:0] CH_SPACE     = 8'h20;
	localparam logic [7:0] CH_TAB       = 8'h09;
	localparam logic [7:0] CH_CR        = 8'h0D;
	localparam logic [7:0] CH_NL        = 8'h0A;
	localparam logic [7:0] CH_HASH      = 8'h23;
	localparam logic [7:0] CH_QUOTE     = 8'h22;
	localparam logic [7:0] CH_UNDERSCORE = 8'h5F;

	// keywords packed first byte in bits 7:0: and or not true false nil
	localparam logic [39:0] KW_TEXT [6] = '{
		40'h00_0064_6E61,
		40'h00_0000_726F,
		40'h00_0074_6F6E,
		40'h00_6575_7274,
		40'h65_736C_6166,
		40'h00_006C_696E
	};
	localparam logic [2:0] KW_LEN [6] = '{3'd3, 3'd2, 3'd3, 3'd4, 3'd5, 3'd3};

endpackage

/* rtl/stt_front.sv */
// ----------------------------------------------------------------------------
// stt_front
// Scanner: classifies each byte against the pending mode and builds the
// group of tokens that the byte completes.
// ----------------------------------------------------------------------------
module stt_front import stt_pkg::*; #(
	parameter int OFFSET_BITS = 24,
	parameter int LINE_BITS   = 24
) (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     accept,
	input  in_item_t item,
	output logic     push,
	output group_t   grp
);

	typedef struct packed {
		logic [5:0]             kind;
		logic [OFFSET_BITS-1:0] start;
		logic [OFFSET_BITS-1:0] len;
	} emit_t;

	localparam logic [OFFSET_BITS-1:0] OFF_MAX  = {OFFSET_BITS{1'b1}};
	localparam logic [LINE_BITS-1:0]   LINE_MAX = {LINE_BITS{1'b1}};
	localparam logic [LINE_BITS-1:0]   LINE_ONE = {{(LINE_BITS-1){1'b0}}, 1'b1};
	localparam logic [OFFSET_BITS-1:0] LEN_ONE  = {{(OFFSET_BITS-1){1'b0}}, 1'b1};
	localparam logic [OFFSET_BITS-1:0] LEN_TWO  = {{(OFFSET_BITS-2){1'b0}}, 2'd2};

	function automatic emit_t mk(input logic [5:0] k, input logic [OFFSET_BITS-1:0] s,
			input logic [OFFSET_BITS-1:0] l);
		emit_t r;
		r.kind  = k;
		r.start = s;
		r.len   = l;
		return r;
	endfunction

	scan_mode_t             mode_q, mode_d;
	logic [OFFSET_BITS-1:0] pos_q, pos_d;
	logic [OFFSET_BITS-1:0] tstart_q, tstart_d;
	logic [LINE_BITS-1:0]   line_q, line_d;
	logic [39:0]            prefix_q, prefix_d;
	logic [2:0]             wlen_q, wlen_d;

	logic [7:0] c;
	logic       eoi;
	logic       is_numeral, is_alpha;

	// what a byte does when nothing is pending
	logic       idle_emit;
	logic [5:0] idle_kind;
	scan_mode_t idle_mode;
	logic       idle_word;

	logic [7:0] pend_second;
	logic [5:0] pend_two, pend_one;

	logic [5:0]             word_kind;
	logic [OFFSET_BITS-1:0] dot_pos, span_p, span_dot, span_str;
	logic                   go;

	emit_t      e [3];
	logic [1:0] n;

	logic [OFFSET_BITS+23:0] start_w [3];
	logic [OFFSET_BITS+23:0] len_w [3];
	logic [LINE_BITS+23:0]   line_w;

	assign c   = item.char_byte;
	assign eoi = item.end_of_input;

	assign is_numeral = (c >= 8'h30) && (c <= 8'h39);
	assign is_alpha = ((c >= 8'h61) && (c <= 8'h7A)) || ((c >= 8'h41) && (c <= 8'h5A)) ||
		(c == CH_UNDERSCORE);

	always_comb begin
		idle_emit = 1'b1;
		idle_kind = KIND_BAD;
		idle_mode = MODE_IDLE;
		idle_word = 1'b0;
		case (c)
			CH_BACKSLASH: idle_kind = KIND_BACKSLASH;
			CH_PLUS:      idle_kind = KIND_PLUS;
			CH_MINUS:     idle_kind = KIND_MINUS;
			CH_STAR:      idle_kind = KIND_STAR;
			CH_CARET:     idle_kind = KIND_CARET;
			CH_LPAREN:    idle_kind = KIND_LPAREN;
			CH_RPAREN:    idle_kind = KIND_RPAREN;
			CH_LBRACK:    idle_kind = KIND_LBRACK;
			CH_RBRACK:    idle_kind = KIND_RBRACK;
			CH_LBRACE:    idle_kind = KIND_LBRACE;
			CH_RBRACE:    idle_kind = KIND_RBRACE;
			CH_COLON:     idle_kind = KIND_COLON;
			CH_COMMA:     idle_kind = KIND_COMMA;
			CH_EQUAL: begin
				idle_emit = 1'b0;
				idle_mode = MODE_EQ;
			end
			CH_LESS: begin
				idle_emit = 1'b0;
				idle_mode = MODE_LT;
			end
			CH_GREATER: begin
				idle_emit = 1'b0;
				idle_mode = MODE_GT;
			end
			CH_DOT: begin
				idle_emit = 1'b0;
				idle_mode = MODE_DOT;
			end
			CH_SLASH: begin
				idle_emit = 1'b0;
				idle_mode = MODE_SLASH;
			end
			CH_SPACE, CH_TAB, CH_CR, CH_NL: idle_emit = 1'b0;
			CH_HASH: begin
				idle_emit = 1'b0;
				idle_mode = MODE_COMMENT;
			end
			CH_QUOTE: begin
				idle_emit = 1'b0;
				idle_mode = MODE_STRING;
			end
			default: begin
				if (is_numeral) begin
					idle_emit = 1'b0;
					idle_mode = MODE_INT;
				end else if (is_alpha) begin
					idle_emit = 1'b0;
					idle_mode = MODE_WORD;
					idle_word = 1'b1;
				end
			end
		endcase
	end

	always_comb begin
		pend_second = CH_EQUAL;
		pend_two    = KIND_EQEQ;
		pend_one    = KIND_EQ;
		case (mode_q)
			MODE_EQ: begin
				pend_two = KIND_EQEQ;
				pend_one = KIND_EQ;
			end
			MODE_LT: begin
				pend_two = KIND_LE;
				pend_one = KIND_LT;
			end
			MODE_GT: begin
				pend_two = KIND_GE;
				pend_one = KIND_GT;
			end
			MODE_DOT: begin
				pend_second = CH_DOT;
				pend_two    = KIND_DOTDOT;
				pend_one    = KIND_DOT;
			end
			MODE_SLASH: begin
				pend_two = KIND_NE;
				pend_one = KIND_SLASH;
			end
			default: ;
		endcase
	end

	always_comb begin
		word_kind = KIND_IDENT;
		if (wlen_q <= 3'd5) begin
			for (int i = 5; i >= 0; i--) begin
				if ((wlen_q == KW_LEN[i]) && (prefix_q == KW_TEXT[i]))
					word_kind = KIND_AND + 6'(i);
			end
		end
	end

	assign dot_pos  = (pos_q != '0) ? pos_q - LEN_ONE : '0;
	assign span_p   = (pos_q > tstart_q) ? pos_q - tstart_q : '0;
	assign span_dot = (dot_pos > tstart_q) ? dot_pos - tstart_q : '0;
	assign span_str = (span_p == OFF_MAX) ? OFF_MAX : span_p + LEN_ONE;

	// next state
	always_comb begin
		mode_d   = mode_q;
		pos_d    = pos_q;
		tstart_d = tstart_q;
		line_d   = line_q;
		prefix_d = prefix_q;
		wlen_d   = wlen_q;
		go       = 1'b0;
		if (eoi) begin
			mode_d   = MODE_IDLE;
			pos_d    = '0;
			tstart_d = '0;
			line_d   = LINE_ONE;
			prefix_d = '0;
			wlen_d   = '0;
		end else begin
			if (pos_q != OFF_MAX)
				pos_d = pos_q + LEN_ONE;
			case (mode_q)
				MODE_IDLE: go = 1'b1;
				MODE_EQ, MODE_LT, MODE_GT, MODE_DOT, MODE_SLASH: begin
					if (c == pend_second)
						mode_d = MODE_IDLE;
					else
						go = 1'b1;
				end
				MODE_COMMENT: go = (c == CH_NL);
				MODE_STRING: begin
					if (c == CH_QUOTE)
						mode_d = MODE_IDLE;
					else if ((c == CH_NL) && (line_q != LINE_MAX))
						line_d = line_q + LINE_ONE;
				end
				MODE_INT: begin
					if (c == CH_DOT)
						mode_d = MODE_NDOT;
					else if (!is_numeral)
						go = 1'b1;
				end
				MODE_NDOT: begin
					if (is_numeral) begin
						mode_d = MODE_FRAC;
					end else begin
						tstart_d = dot_pos;
						if (c == CH_DOT)
							mode_d = MODE_IDLE;
						else
							go = 1'b1;
					end
				end
				MODE_FRAC: go = !is_numeral;
				MODE_WORD: begin
					if (is_alpha || is_numeral) begin
						if (wlen_q < 3'd5)
							prefix_d[{wlen_q, 3'b000} +: 8] = c;
						if (wlen_q < 3'd6)
							wlen_d = wlen_q + 3'd1;
					end else begin
						go = 1'b1;
					end
				end
				default: go = 1'b1;
			endcase
			if (go) begin
				tstart_d = pos_q;
				mode_d   = idle_mode;
				if (idle_word) begin
					prefix_d = {32'd0, c};
					wlen_d   = 3'd1;
				end
				if ((c == CH_NL) && (line_q != LINE_MAX))
					line_d = line_q + LINE_ONE;
			end
		end
	end

	// tokens caused by this byte, in order
	always_comb begin
		n = 2'd0;
		for (int i = 0; i < 3; i++)
			e[i] = '0;
		if (eoi) begin
			case (mode_q)
				MODE_EQ, MODE_LT, MODE_GT, MODE_DOT, MODE_SLASH: begin
					e[n] = mk(pend_one, tstart_q, LEN_ONE);
					n    = n + 2'd1;
				end
				MODE_INT, MODE_FRAC: begin
					e[n] = mk(KIND_NUMBER, tstart_q, span_p);
					n    = n + 2'd1;
				end
				MODE_NDOT: begin
					e[n] = mk(KIND_NUMBER, tstart_q, span_dot);
					n    = n + 2'd1;
					e[n] = mk(KIND_DOT, dot_pos, LEN_ONE);
					n    = n + 2'd1;
				end
				MODE_WORD: begin
					e[n] = mk(word_kind, tstart_q, span_p);
					n    = n + 2'd1;
				end
				MODE_STRING: begin
					e[n] = mk(KIND_UNTERM, tstart_q, span_p);
					n    = n + 2'd1;
				end
				default: ;
			endcase
			e[n] = mk(KIND_EOF, pos_q, '0);
			n    = n + 2'd1;
		end else begin
			case (mode_q)
				MODE_EQ, MODE_LT, MODE_GT, MODE_DOT, MODE_SLASH: begin
					if (c == pend_second) begin
						e[n] = mk(pend_two, tstart_q, LEN_TWO);
						n    = n + 2'd1;
					end else begin
						e[n] = mk(pend_one, tstart_q, LEN_ONE);
						n    = n + 2'd1;
					end
				end
				MODE_STRING: begin
					if (c == CH_QUOTE) begin
						e[n] = mk(KIND_STRING, tstart_q, span_str);
						n    = n + 2'd1;
					end
				end
				MODE_INT, MODE_FRAC: begin
					if (go) begin
						e[n] = mk(KIND_NUMBER, tstart_q, span_p);
						n    = n + 2'd1;
					end
				end
				MODE_NDOT: begin
					if (!is_numeral) begin
						e[n] = mk(KIND_NUMBER, tstart_q, span_dot);
						n    = n + 2'd1;
						if (c == CH_DOT)
							e[n] = mk(KIND_DOTDOT, dot_pos, LEN_TWO);
						else
							e[n] = mk(KIND_DOT, dot_pos, LEN_ONE);
						n = n + 2'd1;
					end
				end
				MODE_WORD: begin
					if (go) begin
						e[n] = mk(word_kind, tstart_q, span_p);
						n    = n + 2'd1;
					end
				end
				default: ;
			endcase
			if (go && idle_emit) begin
				e[n] = mk(idle_kind, pos_q, LEN_ONE);
				n    = n + 2'd1;
			end
		end
	end

	assign line_w = {24'd0, line_q};

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			start_w[i]                  = {24'd0, e[i].start};
			len_w[i]                    = {24'd0, e[i].len};
			grp.res[i].token_kind       = e[i].kind;
			grp.res[i].lexeme_start     = start_w[i][23:0];
			grp.res[i].lexeme_length    = len_w[i][23:0];
			grp.res[i].line_number      = line_w[23:0];
			grp.res[i].last_of_run      = (2'(i) == (n - 2'd1));
		end
		grp.count = n;
	end

	assign push = accept && (n != 2'd0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q   <= MODE_IDLE;
			pos_q    <= '0;
			tstart_q <= '0;
			line_q   <= LINE_ONE;
			prefix_q <= '0;
			wlen_q   <= '0;
		end else if (accept) begin
			mode_q   <= mode_d;
			pos_q    <= pos_d;
			tstart_q <= tstart_d;
			line_q   <= line_d;
			prefix_q <= prefix_d;
			wlen_q   <= wlen_d;
		end
	end

endmodule

/* rtl/stt_queue.sv */
// ----------------------------------------------------------------------------
// stt_queue
// Short queue of token groups between scanner and output serializer.
// ----------------------------------------------------------------------------
module stt_queue import stt_pkg::*; (
	input  logic   clk,
	input  logic   arst_n,
	input  logic   push,
	input  group_t wr_grp,
	input  logic   pop,
	output group_t rd_grp,
	output logic   full,
	output logic   empty
);

	group_t               mem_q [QUEUE_DEPTH];
	logic [QPTR_BITS-1:0] wr_ptr_q, rd_ptr_q;
	logic [QPTR_BITS:0]   count_q;
	logic                 do_push, do_pop;

	assign full    = (count_q == (QPTR_BITS+1)'(QUEUE_DEPTH));
	assign empty   = (count_q == '0);
	assign do_push = push && !full;
	assign do_pop  = pop && !empty;
	assign rd_grp  = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_push)
			mem_q[wr_ptr_q] <= wr_grp;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push)
				wr_ptr_q <= wr_ptr_q + 1'b1;
			if (do_pop)
				rd_ptr_q <= rd_ptr_q + 1'b1;
			if (do_push && !do_pop)
				count_q <= count_q + 1'b1;
			else if (do_pop && !do_push)
				count_q <= count_q - 1'b1;
		end
	end

endmodule

/* rtl/stt_back.sv */
// ----------------------------------------------------------------------------
// stt_back
// Output serializer: holds one token group and hands its tokens out one
// transfer at a time.
// ----------------------------------------------------------------------------
module stt_back import stt_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  group_t  rd_grp,
	input  logic    empty,
	output logic    pop,
	output logic    tok_valid,
	input  logic    tok_stall,
	output result_t tok_data
);

	group_t     grp_q;
	logic [1:0] idx_q;
	logic       busy_q;
	logic       done, load;

	assign done      = busy_q && !tok_stall && (idx_q == (grp_q.count - 2'd1));
	assign load      = !empty && (!busy_q || done);
	assign pop       = load;
	assign tok_valid = busy_q;
	assign tok_data  = grp_q.res[idx_q];

	always_ff @(posedge clk) begin
		if (load)
			grp_q <= rd_grp;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			idx_q  <= '0;
		end else if (load) begin
			busy_q <= 1'b1;
			idx_q  <= '0;
		end else if (done) begin
			busy_q <= 1'b0;
		end else if (busy_q && !tok_stall) begin
			idx_q <= idx_q + 2'd1;
		end
	end

endmodule

/* rtl/source_text_tokenizer.sv */
// ----------------------------------------------------------------------------
// source_text_tokenizer
// Streaming lexical scanner: one source byte in per transfer, tokens out.
// Accepts one byte per cycle unless the queue is full; the byte's tokens go
// into the queue at its transfer, then into the output serializer's register.
// A byte that completes 2 or 3 tokens holds the single output port for one
// transfer per token; a four-group queue lets the scanner run on meanwhile.
// Reset: scanner idle, position 0, line 1, queue and output empty.
// ----------------------------------------------------------------------------
module source_text_tokenizer import stt_pkg::*; #(
	parameter int OFFSET_BITS = 24,
	parameter int LINE_BITS   = 24
) (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     src_valid,
	output logic     src_stall,
	input  in_item_t src_data,
	output logic     tok_valid,
	input  logic     tok_stall,
	output result_t  tok_data
);

	group_t wr_grp, rd_grp;
	logic   push, pop, full, empty, accept;

	assign src_stall = full;
	assign accept    = src_valid && !full;

	stt_front #(
		.OFFSET_BITS(OFFSET_BITS),
		.LINE_BITS  (LINE_BITS)
	) u_front (
		.clk   (clk),
		.arst_n(arst_n),
		.accept(accept),
		.item  (src_data),
		.push  (push),
		.grp   (wr_grp)
	);

	stt_queue u_queue (
		.clk   (clk),
		.arst_n(arst_n),
		.push  (push),
		.wr_grp(wr_grp),
		.pop   (pop),
		.rd_grp(rd_grp),
		.full  (full),
		.empty (empty)
	);

	stt_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.rd_grp   (rd_grp),
		.empty    (empty),
		.pop      (pop),
		.tok_valid(tok_valid),
		.tok_stall(tok_stall),
		.tok_data (tok_data)
	);

endmodule
